/* rtl/stc_pkg.sv */
// Shared constants, payload types and the saturating add for the Steiner tree cost engine.
// No dependencies.
package stc_pkg;
   localparam int MAX_NODES     = 64;
   localparam int MAX_TERMINALS = 8;
   localparam int MAX_EDGES     = 256;
   localparam int COST_WIDTH    = 16;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int NCNT_W  = $clog2(MAX_NODES + 1);
   localparam int TERM_W  = $clog2(MAX_TERMINALS);
   localparam int TCNT_W  = $clog2(MAX_TERMINALS + 1);
   localparam int SUB_W   = MAX_TERMINALS;
   localparam int EDGE_W  = $clog2(MAX_EDGES);
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int COST_W  = 23;
   localparam int TOTAL_W = 22;
   localparam logic [COST_W-1:0] INF_COST = COST_W'(1) << TOTAL_W;

   localparam logic [1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [1:0] OP_SET_TERM = 2'd1;
   localparam logic [1:0] OP_SOLVE    = 2'd2;

   localparam logic CSR_NUM_NODES     = 1'b0;
   localparam logic CSR_NUM_TERMINALS = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  node_a;
      logic [5:0]  node_b;
      logic [15:0] edge_cost;
      logic [2:0]  terminal_slot;
   } req_word_type;

   typedef struct packed {
      logic [21:0] total_cost;
      logic        unreachable;
   } rsp_word_type;

   typedef struct packed {
      logic [NODE_W-1:0]     node_a;
      logic [NODE_W-1:0]     node_b;
      logic [COST_WIDTH-1:0] weight;
   } edge_type;

   function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] x, logic [COST_W-1:0] y);
      logic [COST_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return (s >= {1'b0, INF_COST}) ? INF_COST : s[COST_W-1:0];
   endfunction
endpackage

/* rtl/stc_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on stc_pkg.
interface stc_req_if;
   logic                  valid;
   logic                  ready;
   stc_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface stc_rsp_if;
   logic                  valid;
   logic                  ready;
   stc_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/steiner_tree_min_cost.sv */
// Steiner tree cost engine, top level. Depends on stc_pkg and stc_if.
// Add-edge / set-terminal words: accepted without a response; next word the cycle after.
// Solve: one response after a merge pass over every subset plus, per subset below the
// full set, up to N+1 Dijkstra rounds of node scan and edge scan; one word at a time.
// Reset (synchronous, high): idle, no response pending, edge count 0, num_nodes 64,
// num_terminals 0. Cost table needs no clearing: each row is rebuilt before it is read.
module steiner_tree_min_cost (
   input  logic                        clock,
   input  logic                        reset,
   stc_req_if.sink                     req_chan,
   stc_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [6:0]                  csr_wdata
);
   localparam int AW = stc_pkg::SUB_W + stc_pkg::NODE_W;

   typedef enum logic [4:0] {
      IDLE, CMB_START, CMB_RA, CMB_RB, CMB_ACC, CMB_WR,
      SCAN_INIT, SCAN_RD, SCAN_CHK, EDGE_RD, EDGE_CHK, ROW_RD, ROW_CHK,
      NEXT_SUB, FIN, FIN_CHK, DONE
   } state_type;

   state_type state_ff;

   // config
   logic [6:0] num_nodes_ff;
   logic [3:0] num_terms_ff;

   // stores
   logic [stc_pkg::COST_W-1:0] cost_mem [2**AW];
   logic [stc_pkg::COST_W-1:0] cost_rdata_ff;
   logic [AW-1:0]              cost_raddr, cost_waddr;
   logic [stc_pkg::COST_W-1:0] cost_wdata;
   logic                       cost_we;

   stc_pkg::edge_type          edge_mem [stc_pkg::MAX_EDGES];
   stc_pkg::edge_type          edge_rdata_ff;
   logic                       edge_we;
   logic [stc_pkg::ECNT_W-1:0] edge_count_ff;
   logic [stc_pkg::EDGE_W-1:0] edge_raddr;

   logic [stc_pkg::NODE_W-1:0] term_ff [stc_pkg::MAX_TERMINALS];

   // sequencer
   logic [stc_pkg::SUB_W-1:0]  sub_ff, k_ff;
   logic [stc_pkg::NCNT_W-1:0] node_ff;
   logic [stc_pkg::COST_W-1:0] m_ff, a_ff, best_ff, cand_ff;
   logic [stc_pkg::NODE_W-1:0] pick_ff, other_ff;
   logic                       found_ff;
   logic [stc_pkg::MAX_NODES-1:0] done_ff;
   logic [stc_pkg::ECNT_W-1:0] eidx_ff;

   logic                       rsp_valid_ff;
   stc_pkg::rsp_word_type      rsp_data_ff, res_ff;

   // derived config
   logic [stc_pkg::NCNT_W-1:0] nv;
   logic [stc_pkg::TCNT_W-1:0] tcnt;
   logic [stc_pkg::SUB_W-1:0]  full;
   logic [stc_pkg::SUB_W:0]    full_wide;
   logic [stc_pkg::NCNT_W-1:0] node_nx;
   logic [stc_pkg::COST_W-1:0] init_cost, pair_sum;
   logic [stc_pkg::TERM_W-1:0] single_idx;
   logic [stc_pkg::SUB_W-1:0]  k_first, k_next;
   logic                       req_acc, rsp_free;
   stc_pkg::req_word_type      rq;

   always_comb begin
      if (num_nodes_ff == '0) begin
         nv = stc_pkg::NCNT_W'(1);
      end else if (stc_pkg::NCNT_W'(num_nodes_ff) > stc_pkg::NCNT_W'(stc_pkg::MAX_NODES)) begin
         nv = stc_pkg::NCNT_W'(stc_pkg::MAX_NODES);
      end else begin
         nv = stc_pkg::NCNT_W'(num_nodes_ff);
      end
      tcnt = (stc_pkg::TCNT_W'(num_terms_ff) > stc_pkg::TCNT_W'(stc_pkg::MAX_TERMINALS)) ?
             stc_pkg::TCNT_W'(stc_pkg::MAX_TERMINALS) : stc_pkg::TCNT_W'(num_terms_ff);
      full_wide = ((stc_pkg::SUB_W+1)'(1) << tcnt) - (stc_pkg::SUB_W+1)'(1);
      full = full_wide[stc_pkg::SUB_W-1:0];
   end

   // singleton subset: base cost 0 at its terminal node
   always_comb begin
      single_idx = '0;
      for (int b = 0; b < stc_pkg::SUB_W; b++) begin
         if (sub_ff[b]) single_idx = stc_pkg::TERM_W'(b);
      end
      init_cost = ($onehot(sub_ff) &&
                   stc_pkg::NCNT_W'(term_ff[single_idx]) == node_ff) ? '0 : stc_pkg::INF_COST;
   end

   assign k_first  = (sub_ff - stc_pkg::SUB_W'(1)) & sub_ff;
   assign k_next   = (k_ff - stc_pkg::SUB_W'(1)) & sub_ff;
   assign node_nx  = node_ff + stc_pkg::NCNT_W'(1);
   assign pair_sum = stc_pkg::sat_add(a_ff, cost_rdata_ff);
   assign rq       = req_chan.data;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // cost table port selection
   always_comb begin
      cost_raddr = {sub_ff, node_ff[stc_pkg::NODE_W-1:0]};
      cost_waddr = {sub_ff, node_ff[stc_pkg::NODE_W-1:0]};
      cost_wdata = m_ff;
      cost_we    = 1'b0;
      case (state_ff)
         CMB_RA:   cost_raddr = {k_ff, node_ff[stc_pkg::NODE_W-1:0]};
         CMB_RB:   cost_raddr = {sub_ff ^ k_ff, node_ff[stc_pkg::NODE_W-1:0]};
         CMB_WR:   cost_we    = 1'b1;
         ROW_RD:   cost_raddr = {sub_ff, other_ff};
         ROW_CHK: begin
            cost_waddr = {sub_ff, other_ff};
            cost_wdata = cand_ff;
            cost_we    = (cand_ff < cost_rdata_ff);
         end
         FIN:      cost_raddr = {full, term_ff[0]};
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
      cost_rdata_ff <= cost_mem[cost_raddr];
   end

   assign edge_we    = req_acc && rq.opcode == stc_pkg::OP_ADD_EDGE &&
                       edge_count_ff < stc_pkg::ECNT_W'(stc_pkg::MAX_EDGES);
   assign edge_raddr = eidx_ff[stc_pkg::EDGE_W-1:0];

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_count_ff[stc_pkg::EDGE_W-1:0]] <=
            '{node_a: rq.node_a, node_b: rq.node_b, weight: rq.edge_cost[stc_pkg::COST_WIDTH-1:0]};
      end
      edge_rdata_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && rq.opcode == stc_pkg::OP_SET_TERM &&
          32'(rq.terminal_slot) < stc_pkg::MAX_TERMINALS) begin
         term_ff[rq.terminal_slot[stc_pkg::TERM_W-1:0]] <= rq.node_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff  <= 7'd64;
         num_terms_ff  <= '0;
         edge_count_ff <= '0;
      end else begin
         if (csr_we && csr_index == stc_pkg::CSR_NUM_NODES)     num_nodes_ff <= csr_wdata;
         if (csr_we && csr_index == stc_pkg::CSR_NUM_TERMINALS) num_terms_ff <= csr_wdata[3:0];
         if (edge_we) edge_count_ff <= edge_count_ff + stc_pkg::ECNT_W'(1);
      end
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // DONE reloads the response register itself
         if (rsp_valid_ff && rsp_chan.ready && state_ff != DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (req_acc && rq.opcode == stc_pkg::OP_SOLVE) begin
                  if (tcnt == '0) begin
                     res_ff   <= '{total_cost: '0, unreachable: 1'b0};
                     state_ff <= DONE;
                  end else begin
                     sub_ff   <= stc_pkg::SUB_W'(1);
                     node_ff  <= '0;
                     state_ff <= CMB_START;
                  end
               end
            end
            // merge all split pairs of subset sub at node
            CMB_START: begin
               m_ff     <= init_cost;
               k_ff     <= k_first;
               state_ff <= (k_first == '0) ? CMB_WR : CMB_RA;
            end
            CMB_RA:  state_ff <= CMB_RB;
            CMB_RB: begin
               a_ff     <= cost_rdata_ff;
               state_ff <= CMB_ACC;
            end
            CMB_ACC: begin
               if (pair_sum < m_ff) m_ff <= pair_sum;
               k_ff     <= k_next;
               state_ff <= (k_next == '0) ? CMB_WR : CMB_RA;
            end
            CMB_WR: begin
               if (node_nx == nv) begin
                  node_ff  <= '0;
                  done_ff  <= '0;
                  state_ff <= (sub_ff == full) ? FIN : SCAN_INIT;
               end else begin
                  node_ff  <= node_nx;
                  state_ff <= CMB_START;
               end
            end
            // Dijkstra round: linear scan for the closest unsettled node
            SCAN_INIT: begin
               node_ff  <= '0;
               found_ff <= 1'b0;
               best_ff  <= stc_pkg::INF_COST;
               state_ff <= SCAN_RD;
            end
            SCAN_RD: state_ff <= SCAN_CHK;
            SCAN_CHK: begin
               if (!done_ff[node_ff[stc_pkg::NODE_W-1:0]] && cost_rdata_ff < best_ff) begin
                  best_ff  <= cost_rdata_ff;
                  pick_ff  <= node_ff[stc_pkg::NODE_W-1:0];
                  found_ff <= 1'b1;
               end
               if (node_nx == nv) begin
                  state_ff <= EDGE_RD;
                  eidx_ff  <= '0;
               end else begin
                  node_ff  <= node_nx;
                  state_ff <= SCAN_RD;
               end
            end
            EDGE_RD: begin
               if (!found_ff) begin
                  state_ff <= NEXT_SUB;
               end else if (eidx_ff == edge_count_ff) begin
                  done_ff[pick_ff] <= 1'b1;
                  state_ff         <= SCAN_INIT;
               end else begin
                  state_ff <= EDGE_CHK;
               end
            end
            EDGE_CHK: begin
               cand_ff <= stc_pkg::sat_add(best_ff,
                                           stc_pkg::COST_W'(edge_rdata_ff.weight));
               if (stc_pkg::NCNT_W'(edge_rdata_ff.node_a) < nv &&
                   stc_pkg::NCNT_W'(edge_rdata_ff.node_b) < nv &&
                   (edge_rdata_ff.node_a == pick_ff || edge_rdata_ff.node_b == pick_ff)) begin
                  other_ff <= (edge_rdata_ff.node_a == pick_ff) ?
                              edge_rdata_ff.node_b : edge_rdata_ff.node_a;
                  state_ff <= ROW_RD;
               end else begin
                  eidx_ff  <= eidx_ff + stc_pkg::ECNT_W'(1);
                  state_ff <= EDGE_RD;
               end
            end
            ROW_RD: state_ff <= ROW_CHK;
            ROW_CHK: begin
               eidx_ff  <= eidx_ff + stc_pkg::ECNT_W'(1);
               state_ff <= EDGE_RD;
            end
            NEXT_SUB: begin
               sub_ff   <= sub_ff + stc_pkg::SUB_W'(1);
               node_ff  <= '0;
               state_ff <= CMB_START;
            end
            FIN: begin
               if (stc_pkg::NCNT_W'(term_ff[0]) >= nv) begin
                  res_ff   <= '{total_cost: '0, unreachable: 1'b1};
                  state_ff <= DONE;
               end else begin
                  state_ff <= FIN_CHK;
               end
            end
            FIN_CHK: begin
               if (cost_rdata_ff >= stc_pkg::INF_COST) begin
                  res_ff <= '{total_cost: '0, unreachable: 1'b1};
               end else begin
                  res_ff <= '{total_cost: cost_rdata_ff[stc_pkg::TOTAL_W-1:0],
                              unreachable: 1'b0};
               end
               state_ff <= DONE;
            end
            DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

/* rtl/stc_checker.sv */
// Port-level checks for the Steiner tree cost engine, bound to the top level.
// Depends on stc_pkg and steiner_tree_min_cost.
module stc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input stc_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input stc_pkg::rsp_word_type rsp_data
);
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unreachable |-> rsp_data.total_cost == '0)
      else $error("unreachable response carries nonzero cost");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == stc_pkg::OP_ADD_EDGE |=> req_ready)
      else $error("edge load stalled request side");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without solve");
endmodule

bind steiner_tree_min_cost stc_checker u_stc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_data  (req_chan.data),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

/* verif/tb_top.sv */
// Self-checking testbench for the Steiner tree cost engine (steiner_tree_min_cost).
// Depends on stc_pkg, the stc_req_if / stc_rsp_if channel interfaces and the RTL top.
`timescale 1ns / 100ps

module tb_top;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned COST_INF = 32'h400000;
   localparam int EDGE_CAP_RANDOM = 40;   // keeps solves short
   localparam int LONG_HOLD = 20000;      // receiver hold-off, cycles

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [6:0] csr_wdata;

   stc_req_if req_if ();
   stc_rsp_if rsp_if ();

   steiner_tree_min_cost i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow state of the engine: edge list, terminal slots, registers
   // ---------------------------------------------------------------
   logic [5:0]  sh_edge_a [stc_pkg::MAX_EDGES];
   logic [5:0]  sh_edge_b [stc_pkg::MAX_EDGES];
   logic [15:0] sh_edge_w [stc_pkg::MAX_EDGES];
   int unsigned sh_edge_count;
   logic [5:0]  sh_term [stc_pkg::MAX_TERMINALS];
   logic [6:0]  sh_num_nodes;
   logic [3:0]  sh_num_terms;
   int unsigned tree_cost [1 << stc_pkg::MAX_TERMINALS][stc_pkg::MAX_NODES];
   bit          settled [stc_pkg::MAX_NODES];

   stc_pkg::req_word_type pending_words[$];   // words waiting to be offered
   stc_pkg::rsp_word_type solve_answers[$];   // expected responses, oldest first

   int err_count;
   int words_accepted;
   int solves_checked;
   int unreached_seen;
   int hold_trigger;                 // bumped by stimulus to request a long hold-off
   bit no_idle;                      // stretch with no gaps on either side

   function automatic int unsigned sat_sum(int unsigned x, int unsigned y);
      longint unsigned s;
      s = longint'(x) + longint'(y);
      return (s >= COST_INF) ? COST_INF : int'(s);
   endfunction

   function automatic int unsigned clamp_nodes(logic [6:0] n);
      if (n < 1) return 1;
      if (n > stc_pkg::MAX_NODES) return stc_pkg::MAX_NODES;
      return 32'(n);
   endfunction

   // Shortest-path relaxation of one subset row, O(V^2) node scan.
   function automatic void spread_row(int unsigned sub, int unsigned nv);
      int unsigned best, pick, other, c;
      for (int j = 0; j < stc_pkg::MAX_NODES; j++) settled[j] = 1'b0;
      for (int r = 0; r < nv; r++) begin
         best = COST_INF;
         pick = nv;
         for (int j = 0; j < nv; j++)
            if (!settled[j] && tree_cost[sub][j] < best) begin
               best = tree_cost[sub][j];
               pick = j;
            end
         if (pick == nv) break;
         settled[pick] = 1'b1;
         for (int e = 0; e < sh_edge_count; e++) begin
            if (sh_edge_a[e] >= nv || sh_edge_b[e] >= nv) continue;
            if (sh_edge_a[e] == pick) other = sh_edge_b[e];
            else if (sh_edge_b[e] == pick) other = sh_edge_a[e];
            else continue;
            c = sat_sum(best, sh_edge_w[e]);
            if (c < tree_cost[sub][other]) tree_cost[sub][other] = c;
         end
      end
   endfunction

   function automatic stc_pkg::rsp_word_type steiner_answer();
      stc_pkg::rsp_word_type ans;
      int unsigned nv, nt, full, m, c;
      nv = clamp_nodes(sh_num_nodes);
      nt = (sh_num_terms > stc_pkg::MAX_TERMINALS) ? stc_pkg::MAX_TERMINALS : sh_num_terms;
      ans.total_cost = '0;
      ans.unreachable = 1'b0;
      if (nt == 0) return ans;
      for (int i = 0; i < (1 << stc_pkg::MAX_TERMINALS); i++)
         for (int j = 0; j < stc_pkg::MAX_NODES; j++) tree_cost[i][j] = COST_INF;
      for (int i = 0; i < nt; i++)
         if (sh_term[i] < nv) tree_cost[1 << i][sh_term[i]] = 0;
      full = (1 << nt) - 1;
      for (int unsigned i = 1; i <= full; i++) begin
         for (int j = 0; j < nv; j++) begin
            m = tree_cost[i][j];
            for (int unsigned k = i; k > 0; k = (k - 1) & i) begin
               c = sat_sum(tree_cost[k][j], tree_cost[i ^ k][j]);
               if (c < m) m = c;
            end
            tree_cost[i][j] = m;
         end
         if (i == full) break;
         spread_row(i, nv);
      end
      if (sh_term[0] >= nv || tree_cost[full][sh_term[0]] >= COST_INF)
         ans.unreachable = 1'b1;
      else
         ans.total_cost = 22'(tree_cost[full][sh_term[0]]);
      return ans;
   endfunction

   // Update shadow state for one accepted word; queue an answer for solves.
   function automatic void absorb_word(stc_pkg::req_word_type w);
      case (w.opcode)
         stc_pkg::OP_ADD_EDGE: begin
            if (sh_edge_count < stc_pkg::MAX_EDGES) begin
               sh_edge_a[sh_edge_count] = w.node_a;
               sh_edge_b[sh_edge_count] = w.node_b;
               sh_edge_w[sh_edge_count] = w.edge_cost;
               sh_edge_count++;
            end
         end
         stc_pkg::OP_SET_TERM: begin
            if (w.terminal_slot < stc_pkg::MAX_TERMINALS) sh_term[w.terminal_slot] = w.node_a;
         end
         stc_pkg::OP_SOLVE: solve_answers = {solve_answers, steiner_answer()};
         default: ;   // unused opcode: dropped
      endcase
   endfunction

   function automatic int draw_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
      err_count++;
   endtask

   // ---------------------------------------------------------------
   // Driver: offers queued request words with random gaps
   // ---------------------------------------------------------------
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_word(req_if.data);
            words_accepted++;
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (pending_words.size() > 0) begin
            req_if.data  <= pending_words.pop_front();
            req_if.valid <= 1'b1;
            gap_left = draw_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random ready, long hold-off on request, field checks
   // ---------------------------------------------------------------
   int stall_left;
   int hold_seen;

   always @(posedge clock) begin
      stc_pkg::rsp_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_seen = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (solve_answers.size() == 0) begin
               report_mismatch("response with no solve pending", 1, 0);
            end else begin
               want = solve_answers.pop_front();
               if (rsp_if.data.total_cost !== want.total_cost)
                  report_mismatch("total_cost", rsp_if.data.total_cost, want.total_cost);
               if (rsp_if.data.unreachable !== want.unreachable)
                  report_mismatch("unreachable", rsp_if.data.unreachable, want.unreachable);
               solves_checked++;
               if (want.unreachable) unreached_seen++;
            end
         end
         if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = draw_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_word(logic [1:0] op, logic [5:0] a, logic [5:0] b,
                            logic [15:0] w, logic [2:0] slot);
      stc_pkg::req_word_type x;
      x.opcode = op;
      x.node_a = a;
      x.node_b = b;
      x.edge_cost = w;
      x.terminal_slot = slot;
      pending_words = {pending_words, x};
   endtask

   // Block drained: nothing queued, nothing offered, nothing outstanding.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_if.valid || solve_answers.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == stc_pkg::CSR_NUM_NODES) sh_num_nodes = val;
      else sh_num_terms = val[3:0];
   endtask

   task automatic set_config(logic [6:0] nodes, logic [6:0] terms);
      wait_drained();
      write_csr(stc_pkg::CSR_NUM_NODES, nodes);
      write_csr(stc_pkg::CSR_NUM_TERMINALS, terms);
   endtask

   // Node mostly inside the active range, sometimes anywhere.
   function automatic logic [5:0] pick_node();
      if ($urandom_range(0, 99) < 85)
         return 6'($urandom_range(0, clamp_nodes(sh_num_nodes) - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   function automatic logic [15:0] pick_cost();
      if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 20));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic push_random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)
         push_word(OP_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom), 3'($urandom));
      else if (r < 45 && sh_edge_count + pending_words.size() < EDGE_CAP_RANDOM)
         push_word(stc_pkg::OP_ADD_EDGE, pick_node(), pick_node(), pick_cost(),
                   3'($urandom));
      else if (r < 75)
         push_word(stc_pkg::OP_SET_TERM, pick_node(), 6'($urandom), 16'($urandom),
                   3'($urandom_range(0, 7)));
      else
         push_word(stc_pkg::OP_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom),
                   3'($urandom));
   endtask

   logic [6:0] phase_nodes [9] = '{7'd1, 7'd127, 7'd0, 7'd2, 7'd64, 7'd5, 7'd9, 7'd3, 7'd7};
   logic [6:0] phase_terms [9] = '{7'd15, 7'd2, 7'd1, 7'd8, 7'd1, 7'd3, 7'd0, 7'd2, 7'd4};

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = stc_pkg::CSR_NUM_NODES;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      sh_edge_count = 0;
      sh_num_nodes = 7'd64;
      sh_num_terms = 4'd0;
      err_count = 0;
      words_accepted = 0;
      solves_checked = 0;
      unreached_seen = 0;
      hold_trigger = 0;
      no_idle = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero terminals at reset values, then all slots written.
      push_word(stc_pkg::OP_SOLVE, 6'd63, 6'd63, 16'hFFFF, 3'd7);
      push_word(stc_pkg::OP_SET_TERM, 6'd0, 6'd0, 16'h0000, 3'd0);
      push_word(stc_pkg::OP_SET_TERM, 6'd63, 6'd63, 16'hFFFF, 3'd1);
      for (int s = 2; s < stc_pkg::MAX_TERMINALS; s++)
         push_word(stc_pkg::OP_SET_TERM, 6'(s), 6'd0, 16'd0, 3'(s));
      push_word(stc_pkg::OP_ADD_EDGE, 6'd0, 6'd63, 16'hFFFF, 3'd7);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd63, 6'd0, 16'h0000, 3'd0);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd5, 6'd5, 16'd1, 3'd0);      // self loop
      push_word(stc_pkg::OP_ADD_EDGE, 6'd1, 6'd2, 16'd3, 3'd5);
      push_word(OP_UNUSED, 6'h2A, 6'h15, 16'hA5A5, 3'd6);            // dropped
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);
      set_config(7'd64, 7'd2);                                       // node 0 to node 63
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);
      set_config(7'd8, 7'd3);                                        // terminal 63 beyond count
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);
      push_word(stc_pkg::OP_SET_TERM, 6'd2, 6'd0, 16'd0, 3'd1);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd0, 6'd1, 16'd4, 3'd0);
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);         // connected tree
      push_word(stc_pkg::OP_SET_TERM, 6'd7, 6'd0, 16'd0, 3'd2);
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);         // node 7 isolated

      // Random phases over a spread of register settings.
      for (int ph = 0; ph < 9; ph++) begin
         set_config(phase_nodes[ph], phase_terms[ph]);
         no_idle = (ph == 6);
         if (ph == 7) begin
            // Long receiver hold-off while the sender keeps offering solves.
            hold_trigger++;
            for (int k = 0; k < 4; k++)
               push_word(stc_pkg::OP_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom),
                         3'($urandom));
         end
         for (int k = 0; k < 8; k++) push_random_word();
      end

      // Small graph with a cheaper path around a direct edge and an edge beyond the count.
      set_config(7'd4, 7'd2);
      push_word(stc_pkg::OP_SET_TERM, 6'd0, 6'd0, 16'd0, 3'd0);
      push_word(stc_pkg::OP_SET_TERM, 6'd3, 6'd0, 16'd0, 3'd1);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd0, 6'd1, 16'd5, 3'd0);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd1, 6'd2, 16'd6, 3'd0);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd2, 6'd3, 16'd7, 3'd0);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd0, 6'd3, 16'd20, 3'd0);
      push_word(stc_pkg::OP_ADD_EDGE, 6'd3, 6'd5, 16'd1, 3'd0);
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);
      set_config(7'd1, 7'd1);
      push_word(stc_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0, 3'd0);

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Run covered %0d accepted words and %0d checked solves (%0d unreachable),",
               words_accepted, solves_checked, unreached_seen);
      $display("with node/terminal counts at and beyond their extremes and a long stall.");
      if (err_count == 0 && solve_answers.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #200_000_000;
      $display("Timeout: %0d responses still outstanding", solve_answers.size());
      $display("Verification failed");
      $finish;
   end

endmodule
